FILE: rtl/tic_pkg.sv
// ----------------------------------------------------------------------------
// tic_pkg
// Shared widths, register indexes, controller states and the command and
// status bundles of the thresholded intensity centroid.
// ----------------------------------------------------------------------------
package tic_pkg;

	localparam int GRAY_W = 8;
	localparam int THR_W = 8;
	localparam int FW_W = 12;
	localparam int POS_W = 11;
	localparam int WT_W = 30;
	localparam int MOM_W = 41;
	localparam int NUM_W = MOM_W + 1;
	localparam int QUO_W = POS_W + 1;
	localparam int CNT_W = $clog2(QUO_W);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = FW_W;

	localparam int POS_MAX = (1 << POS_W) - 1;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);
	localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_START_X,
		ST_RUN_X,
		ST_START_Y,
		ST_RUN_Y,
		ST_PUBLISH
	} state_t;

	typedef struct packed {
		logic px;         // pixel word taken this cycle
		logic div_start;
		logic sel_y;
		logic latch_x;
		logic latch_y;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/tic_div.sv
// ----------------------------------------------------------------------------
// tic_div
// Restoring divider, one quotient bit per cycle, with the quotient clamped
// to the largest position value.
// ----------------------------------------------------------------------------
module tic_div
	import tic_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [WT_W-1:0]  den,
	output logic             done,
	output logic [POS_W-1:0] quot
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [MOM_W-1:0] dsh_q;
	logic [QUO_W-1:0] q_q;
	logic             ge;

	assign ge = rem_q >= NUM_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// divisor starts aligned to the top quotient bit and walks down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, (QUO_W-1)'(0)};
			q_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - NUM_W'(dsh_q);
			end
			q_q <= {q_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = q_q[QUO_W-1] ? POS_W'(POS_MAX) : q_q[POS_W-1:0];

endmodule

FILE: rtl/tic_dpath.sv
// ----------------------------------------------------------------------------
// tic_dpath
// Configuration registers, pixel position tracking, saturating moment sums,
// frame snapshot, shared divider and the result register.
// ----------------------------------------------------------------------------
module tic_dpath
	import tic_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [GRAY_W-1:0]     gray_level,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_W-1:0]      center_x,
	output logic [POS_W-1:0]      center_y,
	output logic                  no_bright_pixels
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW_W = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = ((EW_W > FW_W) ? EW_W : FW_W) + 1;
	localparam int ROW_LIM = (MAX_HEIGHT - 1 > POS_MAX) ? POS_MAX : MAX_HEIGHT - 1;
	localparam int PROD_W = COL_W + GRAY_W;
	localparam int RPROD_W = POS_W + GRAY_W;

	logic [THR_W-1:0]   thr_q;
	logic [FW_W-1:0]    fw_q;
	logic [COL_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	logic [WT_W-1:0]    wt_q;
	logic [MOM_W-1:0]   mx_q;
	logic [MOM_W-1:0]   my_q;
	logic [WT_W-1:0]    hold_wt_q;
	logic [MOM_W-1:0]   hold_mx_q;
	logic [MOM_W-1:0]   hold_my_q;
	logic [POS_W-1:0]   qx_q;
	logic [POS_W-1:0]   qy_q;
	logic               out_valid_q;
	logic [POS_W-1:0]   cx_q;
	logic [POS_W-1:0]   cy_q;
	logic               nb_q;

	logic [CMP_W-1:0]   fw_c;
	logic [CMP_W-1:0]   eff_w;
	logic [CMP_W-1:0]   col_inc;
	logic               wrap;
	logic               bright;
	logic [PROD_W-1:0]  colp;
	logic [RPROD_W-1:0] rowp;
	logic [WT_W:0]      wt_sum;
	logic [MOM_W:0]     mx_sum;
	logic [MOM_W:0]     my_sum;
	logic [WT_W-1:0]    wt_nx;
	logic [MOM_W-1:0]   mx_nx;
	logic [MOM_W-1:0]   my_nx;
	logic [COL_W-1:0]   col_nx;
	logic [POS_W-1:0]   row_nx;
	logic [MOM_W-1:0]   num_sel;
	logic [NUM_W-1:0]   div_num;
	logic               div_done;
	logic [POS_W-1:0]   div_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			fw_q <= FW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				REG_FRAME_WIDTH: fw_q <= cfg_data[FW_W-1:0];
				default: ;
			endcase
		end
	end

	// width zero acts as one, above the maximum acts as the maximum
	always_comb begin
		fw_c = CMP_W'(fw_q);
		if (fw_c == '0) begin
			eff_w = CMP_W'(1);
		end else if (fw_c > CMP_W'(MAX_WIDTH)) begin
			eff_w = CMP_W'(MAX_WIDTH);
		end else begin
			eff_w = fw_c;
		end
	end

	assign col_inc = CMP_W'(col_q) + 1'b1;
	assign wrap = col_inc >= eff_w;
	assign col_nx = wrap ? '0 : col_inc[COL_W-1:0];
	assign row_nx = (wrap && (row_q < POS_W'(ROW_LIM))) ? row_q + 1'b1 : row_q;

	assign bright = gray_level > thr_q;
	assign colp = col_q * gray_level;
	assign rowp = row_q * gray_level;
	assign wt_sum = {1'b0, wt_q} + (WT_W+1)'(gray_level);
	assign mx_sum = {1'b0, mx_q} + (MOM_W+1)'(colp);
	assign my_sum = {1'b0, my_q} + (MOM_W+1)'(rowp);

	always_comb begin
		wt_nx = wt_q;
		mx_nx = mx_q;
		my_nx = my_q;
		if (bright) begin
			wt_nx = wt_sum[WT_W] ? '1 : wt_sum[WT_W-1:0];
			mx_nx = mx_sum[MOM_W] ? '1 : mx_sum[MOM_W-1:0];
			my_nx = my_sum[MOM_W] ? '1 : my_sum[MOM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			wt_q <= '0;
			mx_q <= '0;
			my_q <= '0;
		end else if (cmd.px) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
				wt_q <= '0;
				mx_q <= '0;
				my_q <= '0;
			end else begin
				col_q <= col_nx;
				row_q <= row_nx;
				wt_q <= wt_nx;
				mx_q <= mx_nx;
				my_q <= my_nx;
			end
		end
	end

	// frame totals, last pixel included
	always_ff @(posedge clk) begin
		if (cmd.px && frame_end) begin
			hold_wt_q <= wt_nx;
			hold_mx_q <= mx_nx;
			hold_my_q <= my_nx;
		end
	end

	// half the weight added first gives round-half-up
	assign num_sel = cmd.sel_y ? hold_my_q : hold_mx_q;
	assign div_num = {1'b0, num_sel} + NUM_W'(hold_wt_q >> 1);

	tic_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (hold_wt_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_x) begin
			qx_q <= div_quot;
		end
		if (cmd.latch_y) begin
			qy_q <= div_quot;
		end
		if (cmd.publish) begin
			nb_q <= hold_wt_q == '0;
			cx_q <= (hold_wt_q == '0) ? '0 : qx_q;
			cy_q <= (hold_wt_q == '0) ? '0 : qy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign center_x = cx_q;
	assign center_y = cy_q;
	assign no_bright_pixels = nb_q;

endmodule

FILE: rtl/tic_ctrl.sv
// ----------------------------------------------------------------------------
// tic_ctrl
// Sequencer: takes pixels, then runs the x and y divisions on the shared
// divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module tic_ctrl
	import tic_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    frame_end,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (in_valid && frame_end) state_nx = ST_START_X;
			end
			ST_START_X: state_nx = ST_RUN_X;
			ST_RUN_X: begin
				if (status.div_done) state_nx = ST_START_Y;
			end
			ST_START_Y: state_nx = ST_RUN_Y;
			ST_RUN_Y: begin
				if (status.div_done) state_nx = ST_PUBLISH;
			end
			ST_PUBLISH: begin
				if (status.out_free) state_nx = ST_ACCUM;
			end
			default: state_nx = ST_ACCUM;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_ACCUM: begin
				in_ready = 1'b1;
				cmd.px = in_valid;
			end
			ST_START_X: cmd.div_start = 1'b1;
			ST_RUN_X: cmd.latch_x = status.div_done;
			ST_START_Y: begin
				cmd.div_start = 1'b1;
				cmd.sel_y = 1'b1;
			end
			ST_RUN_Y: cmd.latch_y = status.div_done;
			ST_PUBLISH: cmd.publish = status.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/thresholded_intensity_centroid.sv
// ----------------------------------------------------------------------------
// thresholded_intensity_centroid
// Intensity-weighted centroid of pixels above a gray threshold, one result
// word per frame.
// ----------------------------------------------------------------------------
// Pixels: one word per cycle within a frame.
// After the word marked frame_end, input stalls while the x and then the y
// 12-bit quotient run on the shared restoring divider, each after a start
// state, and through the publish state, held longer while an older result waits.
// The result turns valid as input is taken again for the next frame.
// Reset: threshold 128, width 640, positions and sums cleared, no result.
// ----------------------------------------------------------------------------
module thresholded_intensity_centroid
	import tic_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [GRAY_W-1:0]     gray_level,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_W-1:0]      center_x,
	output logic [POS_W-1:0]      center_y,
	output logic                  no_bright_pixels
);

	cmd_t    cmd;
	status_t status;

	tic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.frame_end (frame_end),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tic_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.gray_level       (gray_level),
		.frame_end        (frame_end),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.center_x         (center_x),
		.center_y         (center_y),
		.no_bright_pixels (no_bright_pixels)
	);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thresholded intensity centroid. Pixel words are
// streamed in raster order with random sender gaps and receiver stalls, the
// threshold and frame width are reprogrammed between phases, and every
// centroid word is compared against a bit-accurate moment accumulator.
// ----------------------------------------------------------------------------
import tic_pkg::*;

typedef struct packed {
	logic [POS_W-1:0] cx;
	logic [POS_W-1:0] cy;
	logic             none;
} centroid_t;

class centroid_scoreboard;
	localparam longint unsigned WT_CAP = (64'd1 << WT_W) - 1;
	localparam longint unsigned MOM_CAP = (64'd1 << MOM_W) - 1;

	logic [THR_W-1:0] threshold;
	logic [FW_W-1:0]  width_reg;
	logic [POS_W-1:0] col;
	logic [POS_W-1:0] row;
	logic [WT_W-1:0]  weight;
	logic [MOM_W-1:0] x_moment;
	logic [MOM_W-1:0] y_moment;
	centroid_t        expected_q[$];
	int               errors;

	function new();
		errors = 0;
		threshold = THR_RESET;
		width_reg = FW_RESET;
		clear_sums();
	endfunction

	function void clear_sums();
		col = '0;
		row = '0;
		weight = '0;
		x_moment = '0;
		y_moment = '0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		if (idx == REG_THRESHOLD) begin
			threshold = data[THR_W-1:0];
		end else if (idx == REG_FRAME_WIDTH) begin
			width_reg = data;
		end
	endfunction

	function logic [POS_W-1:0] rounded_mean(longint unsigned num, longint unsigned den);
		longint unsigned q;
		q = (num + den / 2) / den;
		if (q > POS_MAX) q = POS_MAX;
		return q[POS_W-1:0];
	endfunction

	// accepted pixel word: accumulate moments, advance raster position
	function void note_pixel(logic [GRAY_W-1:0] gray, logic last);
		longint unsigned span;
		longint unsigned row_cap;
		longint unsigned acc;
		centroid_t res;
		span = (width_reg == '0) ? 1 : width_reg;
		if (span > DEF_MAX_WIDTH) span = DEF_MAX_WIDTH;
		row_cap = (DEF_MAX_HEIGHT - 1 > POS_MAX) ? POS_MAX : DEF_MAX_HEIGHT - 1;
		if (gray > threshold) begin
			acc = weight;
			acc = acc + gray;
			if (acc > WT_CAP) acc = WT_CAP;
			weight = acc[WT_W-1:0];
			acc = x_moment;
			acc = acc + col * gray;
			if (acc > MOM_CAP) acc = MOM_CAP;
			x_moment = acc[MOM_W-1:0];
			acc = y_moment;
			acc = acc + row * gray;
			if (acc > MOM_CAP) acc = MOM_CAP;
			y_moment = acc[MOM_W-1:0];
		end
		// a column past a freshly narrowed width also wraps here
		if (col + 1 >= span) begin
			col = '0;
			if (row < row_cap) row = row + 1'b1;
		end else begin
			col = col + 1'b1;
		end
		if (last) begin
			if (weight == '0) begin
				res.cx = '0;
				res.cy = '0;
				res.none = 1'b1;
			end else begin
				res.cx = rounded_mean(x_moment, weight);
				res.cy = rounded_mean(y_moment, weight);
				res.none = 1'b0;
			end
			expected_q.insert(expected_q.size(), res);
			clear_sums();
		end
	endfunction

	function void check_result(logic [POS_W-1:0] cx, logic [POS_W-1:0] cy, logic none);
		centroid_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result word: expected none, got x=%0d y=%0d none=%0b",
				$time, cx, cy, none);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (cx !== want.cx) begin
			$display("%0t: center_x expected %0d got %0d", $time, want.cx, cx);
			errors++;
		end
		if (cy !== want.cy) begin
			$display("%0t: center_y expected %0d got %0d", $time, want.cy, cy);
			errors++;
		end
		if (none !== want.none) begin
			$display("%0t: no_bright_pixels expected %0b got %0b", $time, want.none, none);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int LIMIT = 1500000;
	localparam int DRAIN = 40;
	localparam int RANDOM_PIXELS = 1520;
	localparam int CALM_AFTER = 1280;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [GRAY_W-1:0]     gray_level;
	logic                  frame_end;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [POS_W-1:0]      center_x;
	logic [POS_W-1:0]      center_y;
	logic                  no_bright_pixels;

	centroid_scoreboard sb;
	bit calm = 1'b0;
	int pixels_sent = 0;
	int stall_left = 0;
	int cycle_count = 0;

	thresholded_intensity_centroid uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.gray_level(gray_level),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.center_x(center_x),
		.center_y(center_y),
		.no_bright_pixels(no_bright_pixels)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: check accepted words, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(center_x, center_y, no_bright_pixels);
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			out_ready <= 1'b1;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(1, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic push_pixel(logic [GRAY_W-1:0] g, logic last);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		gray_level <= g;
		frame_end <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(g, last);
		pixels_sent++;
	endtask

	// idle point: every result back, then let the divider finish any tail work
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [GRAY_W-1:0] pick_gray();
		int level;
		case ($urandom_range(0, 5))
			0: level = 0;
			1: level = 255;
			2, 3: level = int'(sb.threshold) + int'($urandom_range(0, 4)) - 2;
			default: level = $urandom_range(0, 255);
		endcase
		if (level < 0) level = 0;
		else if (level > 255) level = 255;
		return level[GRAY_W-1:0];
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 12'd4095;
			2: return 12'd2048;
			3: return CFG_DATA_W'($urandom_range(2049, 4095));
			4, 5: return CFG_DATA_W'($urandom_range(17, 300));
			default: return CFG_DATA_W'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_DATA_W'(255);
			default: return CFG_DATA_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(int len, bit close);
		for (int i = 0; i < len; i++)
			push_pixel(pick_gray(), close && i == len - 1);
	endtask

	initial begin
		int nframes;
		int len;
		bit cut;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		gray_level = '0;
		frame_end = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: single bright pixel, then a level equal to threshold
		push_pixel(8'd255, 1'b1);
		push_pixel(8'd128, 1'b0);
		push_pixel(8'd0, 1'b1);
		settle();
		// zero threshold, width 2: half-pixel mean rounds up; gray 0 never counts
		cfg_write(REG_THRESHOLD, '0);
		cfg_write(REG_FRAME_WIDTH, 12'd2);
		push_pixel(8'd10, 1'b0);
		push_pixel(8'd10, 1'b1);
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd0, 1'b1);
		settle();
		// nothing can exceed 255
		cfg_write(REG_THRESHOLD, CFG_DATA_W'(255));
		push_pixel(8'd255, 1'b0);
		push_pixel(8'd255, 1'b1);
		settle();
		// width 0 acts as 1
		cfg_write(REG_THRESHOLD, CFG_DATA_W'(254));
		cfg_write(REG_FRAME_WIDTH, '0);
		push_pixel(8'd255, 1'b0);
		push_pixel(8'd255, 1'b0);
		push_pixel(8'd255, 1'b1);
		settle();
		// oversized width clamps to max
		cfg_write(REG_THRESHOLD, CFG_DATA_W'(100));
		cfg_write(REG_FRAME_WIDTH, 12'd4095);
		push_pixel(8'd200, 1'b0);
		push_pixel(8'd50, 1'b0);
		push_pixel(8'd101, 1'b1);
		settle();
		// narrow the width in the middle of a row
		cfg_write(REG_FRAME_WIDTH, 12'd8);
		repeat (5) push_pixel(8'd200, 1'b0);
		settle();
		cfg_write(REG_FRAME_WIDTH, 12'd3);
		push_pixel(8'd200, 1'b0);
		push_pixel(8'd150, 1'b0);
		push_pixel(8'd255, 1'b1);
		settle();

		pixels_sent = 0;
		while (pixels_sent < RANDOM_PIXELS) begin
			calm = (pixels_sent >= CALM_AFTER);
			settle();
			if ($urandom_range(0, 2) != 0) cfg_write(REG_THRESHOLD, pick_threshold());
			if ($urandom_range(0, 2) != 0) cfg_write(REG_FRAME_WIDTH, pick_width());
			nframes = $urandom_range(1, 4);
			for (int f = 0; f < nframes; f++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 200)
					: $urandom_range(1, 48);
				// an open frame carries over into the next phase's width
				cut = (f == nframes - 1) && ($urandom_range(0, 4) == 0);
				send_frame(len, !cut);
			end
		end
		// close any frame left open
		push_pixel(pick_gray(), 1'b1);

		settle();
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
